// File: rtl/rsbu_pkg.sv
// Shared types and codes for the rotate, shift, swap and bit unit.
`default_nettype none

package rsbu_pkg;

  // Operation codes as they arrive on the input stream.
  typedef enum logic [3:0] {
    OP_RLCA = 4'd0,
    OP_RRCA = 4'd1,
    OP_RLA  = 4'd2,
    OP_RRA  = 4'd3,
    OP_RLC  = 4'd4,
    OP_RRC  = 4'd5,
    OP_RL   = 4'd6,
    OP_RR   = 4'd7,
    OP_SLA  = 4'd8,
    OP_SRA  = 4'd9,
    OP_SWAP = 4'd10,
    OP_SRL  = 4'd11,
    OP_BIT  = 4'd12,
    OP_RES  = 4'd13,
    OP_SET  = 4'd14,
    OP_NOP  = 4'd15
  } op_e;

  // Operand target codes and register file slots.
  localparam logic [2:0] TGT_H   = 3'd4;
  localparam logic [2:0] TGT_L   = 3'd5;
  localparam logic [2:0] TGT_MEM = 3'd6;
  localparam logic [2:0] TGT_A   = 3'd7;
  localparam logic [2:0] SLOT_A  = 3'd6;
  localparam int unsigned NumRegs = 7;

  // Stream payload widths.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] value;
    flags_t     flags;
  } alu_out_t;

endpackage

`default_nettype wire

// File: rtl/rsbu_alu.sv
// Combinational datapath for the rotate, shift, swap and bit operations.
`default_nettype none

module rsbu_alu
  import rsbu_pkg::*;
(
  input  op_e        op_i,
  input  logic [7:0] operand_i,
  input  logic [2:0] bit_num_i,
  input  flags_t     flags_i,
  output alu_out_t   res_o
);

  logic [7:0] v;
  logic [7:0] mask;
  logic       cin;

  assign v    = operand_i;
  assign mask = 8'd1 << bit_num_i;
  assign cin  = flags_i.c;

  // Compute the new value and flags; prefixed shifts test the result for zero.
  always_comb begin
    res_o = '0;
    case (op_i)
      OP_RLCA: begin
        res_o.value = {v[6:0], v[7]};
        res_o.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: v[7]};
      end
      OP_RRCA: begin
        res_o.value = {v[0], v[7:1]};
        res_o.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: v[0]};
      end
      OP_RLA: begin
        res_o.value = {v[6:0], cin};
        res_o.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: v[7]};
      end
      OP_RRA: begin
        res_o.value = {cin, v[7:1]};
        res_o.flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: v[0]};
      end
      OP_RLC: begin
        res_o.value = {v[6:0], v[7]};
        res_o.flags = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      OP_RRC: begin
        res_o.value = {v[0], v[7:1]};
        res_o.flags = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      OP_RL: begin
        res_o.value = {v[6:0], cin};
        res_o.flags = '{z: ({v[6:0], cin} == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      OP_RR: begin
        res_o.value = {cin, v[7:1]};
        res_o.flags = '{z: ({cin, v[7:1]} == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      OP_SLA: begin
        res_o.value = {v[6:0], 1'b0};
        res_o.flags = '{z: (v[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      OP_SRA: begin
        res_o.value = {v[7], v[7:1]};
        res_o.flags = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      OP_SWAP: begin
        res_o.value = {v[3:0], v[7:4]};
        res_o.flags = '{z: (v == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      OP_SRL: begin
        res_o.value = {1'b0, v[7:1]};
        res_o.flags = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      OP_BIT: begin
        res_o.value = v;
        res_o.flags = '{z: ((v & mask) == 8'd0), n: 1'b0, h: 1'b1, c: cin};
      end
      OP_RES: begin
        res_o.value = v & ~mask;
        res_o.flags = flags_i;
      end
      OP_SET: begin
        res_o.value = v | mask;
        res_o.flags = flags_i;
      end
      default: begin
        // No-op code: value reads as zero and the flags stay.
        res_o.value = 8'd0;
        res_o.flags = flags_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rotate_shift_bit_unit.sv
// Top level of the rotate, shift, swap and bit execution unit.
`default_nettype none

// Executes one rotate, shift, swap or bit instruction per input transfer and
// returns one result transfer for each. An instruction is held in the
// input register, is executed there against the register file, flags and
// program counter, and lands in the output register; a new instruction
// is taken every cycle while the output side keeps up, so throughput is one
// instruction per clock. Throughput is set by the state update: the next
// instruction sees the registers, flags and PC that this one leaves. A stall
// on the output holds the output register and, through it, the input register.
module rotate_shift_bit_unit
  import rsbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] operation, [6:4] target, [9:7] bit_number, [17:10] memory_byte,
  // [23:18] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] result_byte, [8] flag_zero, [9] flag_subtract, [10] flag_half,
  // [11] flag_carry, [12] memory_write, [28:13] memory_address,
  // [44:29] next_pc, [47:45] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  // Input register.
  logic       in_valid_q;
  op_e        op_q;
  logic [2:0] tgt_q;
  logic [2:0] bitn_q;
  logic [7:0] mbyte_q;

  // Architectural state.
  logic [7:0]  regs_q [NumRegs];
  flags_t      flags_q;
  logic [15:0] pc_q;

  // Output register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic        advance;
  logic        is_acc;
  logic        is_nop;
  logic        is_mem;
  logic [2:0]  slot;
  logic [7:0]  operand;
  logic [15:0] addr;
  logic [15:0] pc_d;
  logic        mem_wr;
  logic        reg_wr;
  logic [2:0]  wr_slot;
  alu_out_t    alu_res;

  // The instruction moves on when the output register is free or drains now.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Decode.
  assign is_acc  = (op_q == OP_RLCA) || (op_q == OP_RRCA) ||
                   (op_q == OP_RLA)  || (op_q == OP_RRA);
  assign is_nop  = (op_q == OP_NOP);
  assign is_mem  = (tgt_q == TGT_MEM);
  assign slot    = (tgt_q == TGT_A) ? SLOT_A : tgt_q;
  assign addr    = {regs_q[TGT_H], regs_q[TGT_L]};
  assign operand = is_acc ? regs_q[SLOT_A] : (is_mem ? mbyte_q : regs_q[slot]);

  rsbu_alu u_alu (
    .op_i      (op_q),
    .operand_i (operand),
    .bit_num_i (bitn_q),
    .flags_i   (flags_q),
    .res_o     (alu_res)
  );

  // Write-back selection and PC step.
  assign mem_wr  = !is_acc && !is_nop && (op_q != OP_BIT) && is_mem;
  assign reg_wr  = is_acc || (!is_nop && (op_q != OP_BIT) && !is_mem);
  assign wr_slot = is_acc ? SLOT_A : slot;
  assign pc_d    = pc_q + ((is_acc || is_nop) ? 16'd1 : 16'd2);

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q    <= op_e'(s_axis_tdata[3:0]);
      tgt_q   <= s_axis_tdata[6:4];
      bitn_q  <= s_axis_tdata[9:7];
      mbyte_q <= s_axis_tdata[17:10];
    end
  end

  // State update, one instruction per advance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= 8'd0;
      end
      flags_q <= '0;
      pc_q    <= 16'd0;
    end else if (advance) begin
      if (reg_wr) begin
        regs_q[wr_slot] <= alu_res.value;
      end
      flags_q <= alu_res.flags;
      pc_q    <= pc_d;
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'd0, pc_d, addr, mem_wr, alu_res.flags.c, alu_res.flags.h,
                     alu_res.flags.n, alu_res.flags.z, alu_res.value};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/rsbu_checker.sv
// Port-level assertions for the rotate, shift, swap and bit unit, with bind.
`default_nettype none

module rsbu_checker
  import rsbu_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic        out_xfer;
  logic [15:0] last_pc_q;
  logic [15:0] pc_diff;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign pc_diff  = m_axis_tdata[44:29] - last_pc_q;

  // Track the program counter of the last delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pc_q <= 16'd0;
    end else if (out_xfer) begin
      last_pc_q <= m_axis_tdata[44:29];
    end
  end

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // Consecutive results advance the program counter by one or two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (pc_diff == 16'd1 || pc_diff == 16'd2))
    else $error("program counter step is neither one nor two");

  // A memory write comes only from a prefixed instruction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && m_axis_tdata[12] |-> pc_diff == 16'd2)
    else $error("memory write without a two-byte instruction");

  // No instruction of this unit ever sets the subtract flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[9])
    else $error("subtract flag set");

endmodule

bind rotate_shift_bit_unit rsbu_checker u_rsbu_checker (.*);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking stream testbench for the rotate, shift, swap and bit unit.
`timescale 1ns / 100ps

module testbench;
  import rsbu_pkg::*;

  // Input transfer layout, most significant field first.
  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] mem_byte;
    logic [2:0] bit_sel;
    logic [2:0] tgt;
    op_e        op;
  } instr_t;

  // Result transfer layout, most significant field first.
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] next_pc;
    logic [15:0] mem_addr;
    logic        mem_wr;
    logic        c;
    logic        h;
    logic        n;
    logic        z;
    logic [7:0]  value;
  } result_t;

  localparam int unsigned RandomPerPhase = 288;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned MaxReports     = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the architectural state.
  logic [7:0]  shadow_regs [NumRegs];
  flags_t      shadow_flags;
  logic [15:0] shadow_pc;

  instr_t  instr_queue [$];
  result_t expected_results [$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned instr_count = 0;
  int unsigned result_count = 0;
  int unsigned mem_write_count = 0;
  int unsigned zero_count = 0;

  rotate_shift_bit_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Executes one instruction on the shadow state and returns its result.
  function automatic result_t execute_instr(instr_t ins);
    logic [7:0] src;
    logic [7:0] nv;
    logic [7:0] mask;
    logic       cin;
    logic [2:0] slot;
    logic       is_mem;
    result_t    r;
    r = '0;
    r.mem_addr = {shadow_regs[TGT_H], shadow_regs[TGT_L]};
    cin = shadow_flags.c;
    mask = 8'h01 << ins.bit_sel;
    slot = (ins.tgt == TGT_A) ? SLOT_A : ins.tgt;
    is_mem = (ins.tgt == TGT_MEM);
    nv = '0;
    case (ins.op)
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        // Accumulator rotates always clear Z.
        src = shadow_regs[SLOT_A];
        case (ins.op)
          OP_RLCA: nv = {src[6:0], src[7]};
          OP_RRCA: nv = {src[0], src[7:1]};
          OP_RLA:  nv = {src[6:0], cin};
          default: nv = {cin, src[7:1]};
        endcase
        shadow_flags = '{1'b0, 1'b0, 1'b0,
                         (ins.op == OP_RLCA || ins.op == OP_RLA) ? src[7] : src[0]};
        shadow_regs[SLOT_A] = nv;
        shadow_pc = shadow_pc + 16'd1;
      end
      OP_NOP: begin
        shadow_pc = shadow_pc + 16'd1;
      end
      default: begin
        // Prefixed operations on a register or the memory byte.
        src = is_mem ? ins.mem_byte : shadow_regs[slot];
        case (ins.op)
          OP_RLC: begin
            nv = {src[6:0], src[7]};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[7]};
          end
          OP_RRC: begin
            nv = {src[0], src[7:1]};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[0]};
          end
          OP_RL: begin
            nv = {src[6:0], cin};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[7]};
          end
          OP_RR: begin
            nv = {cin, src[7:1]};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[0]};
          end
          OP_SLA: begin
            nv = {src[6:0], 1'b0};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[7]};
          end
          OP_SRA: begin
            nv = {src[7], src[7:1]};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[0]};
          end
          OP_SWAP: begin
            nv = {src[3:0], src[7:4]};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, 1'b0};
          end
          OP_SRL: begin
            nv = {1'b0, src[7:1]};
            shadow_flags = '{nv == 8'h00, 1'b0, 1'b0, src[0]};
          end
          OP_BIT: begin
            nv = src;
            shadow_flags = '{(src & mask) == 8'h00, 1'b0, 1'b1, cin};
          end
          OP_RES: nv = src & ~mask;
          default: nv = src | mask;
        endcase
        if (ins.op != OP_BIT) begin
          if (is_mem) begin
            r.mem_wr = 1'b1;
          end else begin
            shadow_regs[slot] = nv;
          end
        end
        shadow_pc = shadow_pc + 16'd2;
      end
    endcase
    r.value = nv;
    r.z = shadow_flags.z;
    r.n = shadow_flags.n;
    r.h = shadow_flags.h;
    r.c = shadow_flags.c;
    r.next_pc = shadow_pc;
    return r;
  endfunction

  task automatic push_instr(op_e op, logic [2:0] tgt, logic [2:0] bit_sel,
                            logic [7:0] mem_byte);
    instr_t ins;
    ins = '0;
    ins.op = op;
    ins.tgt = tgt;
    ins.bit_sel = bit_sel;
    ins.mem_byte = mem_byte;
    instr_queue.push_back(ins);
  endtask

  task automatic push_random(int unsigned count);
    logic [7:0] mb;
    for (int unsigned i = 0; i < count; i++) begin
      // Bias the memory byte toward its extremes now and then.
      case ($urandom_range(0, 7))
        0: mb = 8'h00;
        1: mb = 8'hFF;
        default: mb = 8'($urandom);
      endcase
      push_instr(op_e'(4'($urandom_range(0, 15))), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7)), mb);
    end
  endtask

  // Blocks until every queued instruction has been sent and answered.
  task automatic wait_drained();
    while (instr_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      if (error_count <= MaxReports) begin
        $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                 name, result_count, exp_val, act_val);
      end
    end
  endtask

  // Driver: presents queued instructions and predicts each accepted transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(execute_instr(instr_t'(s_axis_tdata)));
        instr_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (instr_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= instr_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t act;
    result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act = result_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) begin
            $display("Unexpected result transfer: 0x%0h", m_axis_tdata);
          end
        end else begin
          exp_res = expected_results.pop_front();
          check_field("result_byte", exp_res.value, act.value);
          check_field("flag_zero", exp_res.z, act.z);
          check_field("flag_subtract", exp_res.n, act.n);
          check_field("flag_half", exp_res.h, act.h);
          check_field("flag_carry", exp_res.c, act.c);
          check_field("memory_write", exp_res.mem_wr, act.mem_wr);
          check_field("memory_address", exp_res.mem_addr, act.mem_addr);
          check_field("next_pc", exp_res.next_pc, act.next_pc);
          if (exp_res.mem_wr) mem_write_count++;
          if (exp_res.z) zero_count++;
        end
        result_count++;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumRegs; i++) shadow_regs[i] = '0;
    shadow_flags = '0;
    shadow_pc = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: every operation, flag corner and target kind.
    push_instr(OP_SET,  TGT_A,   3'd7, 8'h00);  // A = 0x80
    push_instr(OP_RLCA, 3'd0,    3'd0, 8'hFF);  // carry out of bit 7
    push_instr(OP_RRA,  3'd5,    3'd3, 8'h00);  // carry back into bit 7
    push_instr(OP_RLA,  3'd2,    3'd7, 8'hA5);
    push_instr(OP_RRCA, TGT_MEM, 3'd1, 8'hFF);
    push_instr(OP_SET,  3'd0,    3'd0, 8'h00);  // B = 0x01
    push_instr(OP_SET,  3'd0,    3'd7, 8'hFF);  // B = 0x81
    push_instr(OP_RLC,  3'd0,    3'd0, 8'h00);
    push_instr(OP_RRC,  3'd0,    3'd0, 8'h00);
    push_instr(OP_RL,   3'd1,    3'd0, 8'h00);  // carry in gives C = 0x01
    push_instr(OP_RR,   3'd1,    3'd0, 8'h00);  // result zero, carry set
    push_instr(OP_SLA,  TGT_MEM, 3'd0, 8'hFF);
    push_instr(OP_SRA,  TGT_MEM, 3'd0, 8'h80);  // sign bit kept
    push_instr(OP_SWAP, TGT_MEM, 3'd0, 8'hF0);
    push_instr(OP_SRL,  TGT_MEM, 3'd0, 8'h01);  // zero result from memory
    push_instr(OP_SET,  TGT_H,   3'd3, 8'h00);  // HL = 0x0800
    push_instr(OP_SET,  TGT_L,   3'd0, 8'h00);  // HL = 0x0801
    push_instr(OP_BIT,  TGT_MEM, 3'd7, 8'h00);  // memory BIT writes nothing
    push_instr(OP_BIT,  TGT_MEM, 3'd0, 8'hFF);
    push_instr(OP_RES,  TGT_MEM, 3'd0, 8'hFF);
    push_instr(OP_SET,  TGT_MEM, 3'd7, 8'h00);
    push_instr(OP_BIT,  TGT_H,   3'd3, 8'h00);
    push_instr(OP_RES,  TGT_H,   3'd3, 8'hFF);
    push_instr(OP_NOP,  TGT_MEM, 3'd7, 8'hFF);  // no-op code, value reads as zero
    push_instr(OP_SWAP, 3'd2,    3'd0, 8'h00);  // zero register, carry cleared

    // Random phases with different amounts of idling on each side.
    push_random(RandomPerPhase);
    wait_drained();
    idle_pct = 60;
    stall_pct = 0;
    push_random(RandomPerPhase);
    wait_drained();
    idle_pct = 0;
    stall_pct = 60;
    push_random(RandomPerPhase);
    wait_drained();
    idle_pct = 25;
    stall_pct = 25;
    push_random(RandomPerPhase);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d instructions and checked %0d results in %0d cycles.",
             instr_count, result_count, cycle_count);
    $display("Saw %0d memory write-backs and %0d results with Z set; %0d errors.",
             mem_write_count, zero_count, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
